[design/sons_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sons_pkg: shared types and constants for sum_of_n_smallest
// Beat structs, cell control struct, store depth and status codes.
// ----------------------------------------------------------------------------
package sons_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int VALUE_W   = 16;
    localparam int TOTAL_W   = 20;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 6;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEG   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_COUNT = 2'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_beat_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total;
        logic [STATUS_W-1:0] status;
    } out_beat_t;

    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctrl_t;

endpackage : sons_pkg
`default_nettype wire

[design/sons_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sons_cell: one compare-insert cell of the sorted row
// Holds one value; on insert it keeps, takes the new value or takes its
// left neighbor's value; on shift it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module sons_cell (
    input  wire                                     clk,
    input  sons_pkg::cell_ctrl_t                    ctrl,
    input  wire logic signed [sons_pkg::VALUE_W-1:0] new_value,
    input  wire logic                                empty,
    input  wire logic                                prev_take,
    input  wire logic signed [sons_pkg::VALUE_W-1:0] prev_value,
    input  wire logic signed [sons_pkg::VALUE_W-1:0] next_value,
    output logic                                     take,
    output logic signed [sons_pkg::VALUE_W-1:0]      value
);

    logic signed [sons_pkg::VALUE_W-1:0] stored_reg;
    logic signed [sons_pkg::VALUE_W-1:0] stored_next;

    always_comb
    begin
        take = empty || (stored_reg > new_value);
    end

    always_comb
    begin
        stored_next = stored_reg;
        priority if (ctrl.ins)
        begin
            if (take)
            begin
                stored_next = prev_take ? prev_value : new_value;
            end
        end
        else if (ctrl.shift)
        begin
            stored_next = next_value;
        end
        else
        begin
            stored_next = stored_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        stored_reg <= stored_next;
    end

    assign value = stored_reg;

endmodule : sons_cell
`default_nettype wire

[design/sum_of_n_smallest.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sum_of_n_smallest: sum of the count_to_sum smallest values of a set
// Input beats carry one signed value each; the beat with last set closes
// the set. Values are kept ascending in a row of MAX_ITEMS compare-insert
// cells; one value is taken per cycle while loading.
// After the last beat the row shifts toward cell 0 once per cycle and
// cell 0 feeds the accumulator; in_stall stays high from the last beat
// until the result beat is written into the output register.
// The result beat is written once the shift-out is done and the output
// register is free, and is held in that register until out_stall is low;
// while it is held a new set may already load, and the next drain
// shifts out but does not finish until the held beat is taken.
// status: 0 ok, 1 negative value seen, 2 count exceeds set size; total is 0
// on error and saturates at all ones. The store saturates at MAX_ITEMS,
// dropping the largest value. cfg_we writes count_to_sum (reset 0), to be
// done only while idle. Reset (rst_n low) empties the set and clears the
// output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sum_of_n_smallest (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_we,
    input  wire [sons_pkg::CFG_W-1:0]   cfg_data,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  sons_pkg::in_beat_t          in_beat,
    output logic                        out_valid,
    input  wire                         out_stall,
    output sons_pkg::out_beat_t         out_beat
);

    localparam logic [0:0] ST_LOAD = 1'b0;
    localparam logic [0:0] ST_SUM  = 1'b1;

    logic [0:0]                       state_reg;
    logic [0:0]                       state_next;
    logic [sons_pkg::CFG_W-1:0]       count_reg;
    logic [sons_pkg::CNT_W-1:0]       items_reg;
    logic [sons_pkg::CNT_W-1:0]       items_next;
    logic                             neg_reg;
    logic                             neg_next;
    logic [sons_pkg::CNT_W-1:0]       rem_reg;
    logic [sons_pkg::CNT_W-1:0]       rem_next;
    logic [sons_pkg::TOTAL_W-1:0]     acc_reg;
    logic [sons_pkg::TOTAL_W-1:0]     acc_next;
    logic [sons_pkg::STATUS_W-1:0]    status_reg;
    logic [sons_pkg::STATUS_W-1:0]    status_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    sons_pkg::out_beat_t              out_reg;
    sons_pkg::out_beat_t              out_next;

    logic                             in_fire;
    logic                             finish;
    logic [sons_pkg::CNT_W-1:0]       items_bump;
    logic                             count_exceeds;
    logic                             neg_now;
    logic [sons_pkg::TOTAL_W:0]       acc_sum;
    sons_pkg::cell_ctrl_t             ctrl;

    logic signed [sons_pkg::VALUE_W-1:0] cell_value [sons_pkg::MAX_ITEMS];
    logic                                cell_take  [sons_pkg::MAX_ITEMS];

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    assign ctrl.ins   = in_fire;
    assign ctrl.shift = (state_reg == ST_SUM) && (rem_reg != '0);

    genvar gi;
    generate
        for (gi = 0; gi < sons_pkg::MAX_ITEMS; gi++)
        begin : g_cell
            logic                                cell_empty;
            logic                                left_take;
            logic signed [sons_pkg::VALUE_W-1:0] left_value;
            logic signed [sons_pkg::VALUE_W-1:0] right_value;

            assign cell_empty = (sons_pkg::CNT_W'(gi) >= items_reg);

            if (gi == 0)
            begin : g_head
                assign left_take  = 1'b0;
                assign left_value = in_beat.value;
            end
            else
            begin : g_body
                assign left_take  = cell_take[gi-1];
                assign left_value = cell_value[gi-1];
            end

            if (gi == sons_pkg::MAX_ITEMS - 1)
            begin : g_tail
                assign right_value = cell_value[gi];
            end
            else
            begin : g_inner
                assign right_value = cell_value[gi+1];
            end

            sons_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .new_value  (in_beat.value),
                .empty      (cell_empty),
                .prev_take  (left_take),
                .prev_value (left_value),
                .next_value (right_value),
                .take       (cell_take[gi]),
                .value      (cell_value[gi])
            );
        end
    endgenerate

    always_comb
    begin
        items_bump    = (items_reg == sons_pkg::CNT_W'(sons_pkg::MAX_ITEMS)) ?
                        items_reg : items_reg + 1'b1;
        count_exceeds = (sons_pkg::CMP_W'(count_reg) > sons_pkg::CMP_W'(items_bump));
        neg_now       = neg_reg || in_beat.value[sons_pkg::VALUE_W-1];
        acc_sum       = {1'b0, acc_reg}
                      + {{(sons_pkg::TOTAL_W + 1 - sons_pkg::VALUE_W){1'b0}}, cell_value[0]};
        finish        = (state_reg == ST_SUM) && (rem_reg == '0)
                      && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next     = state_reg;
        items_next     = items_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    items_next = items_bump;
                    neg_next   = neg_now;
                    if (in_beat.last)
                    begin
                        state_next = ST_SUM;
                        acc_next   = '0;
                        priority if (count_exceeds)
                        begin
                            status_next = sons_pkg::STATUS_COUNT;
                            rem_next    = '0;
                        end
                        else if (neg_now)
                        begin
                            status_next = sons_pkg::STATUS_NEG;
                            rem_next    = '0;
                        end
                        else
                        begin
                            status_next = sons_pkg::STATUS_OK;
                            rem_next    = sons_pkg::CNT_W'(count_reg);
                        end
                    end
                end
            end
            ST_SUM:
            begin
                if (rem_reg != '0)
                begin
                    rem_next = rem_reg - 1'b1;
                    acc_next = acc_sum[sons_pkg::TOTAL_W] ? sons_pkg::TOTAL_MAX
                             : acc_sum[sons_pkg::TOTAL_W-1:0];
                end
                else if (finish)
                begin
                    state_next     = ST_LOAD;
                    items_next     = '0;
                    neg_next       = 1'b0;
                    out_valid_next = 1'b1;
                    out_next.status = status_reg;
                    out_next.total  = (status_reg == sons_pkg::STATUS_OK) ? acc_reg : '0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            items_reg     <= '0;
            neg_reg       <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            items_reg     <= items_next;
            neg_reg       <= neg_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

`ifndef ASSERT_OFF
    a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_beat.last |=> state_reg == ST_SUM)
        else $error("last beat did not start the drain");

    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_SUM)
        else $error("result beat without a drain");

    a_error_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.status != sons_pkg::STATUS_OK |-> out_beat.total == '0)
        else $error("error status with nonzero total");

    a_items_bound: assert property (@(posedge clk) disable iff (!rst_n)
        items_reg <= sons_pkg::CNT_W'(sons_pkg::MAX_ITEMS))
        else $error("item count beyond store depth");
`endif

endmodule : sum_of_n_smallest
`default_nettype wire
